// ===== rtl/core/asti_pkg.sv =====
`timescale 1ns / 1ps

package asti_pkg;

    localparam int SINE_W  = 14;
    localparam int ANGLE_W = 15;
    localparam int TAB_W   = 14;
    localparam int IDX_W   = 7;
    localparam int FRAC_W  = 6;
    localparam int MAG_W   = IDX_W + FRAC_W;
    localparam int DIFF_W  = 10;
    localparam int PROD_W  = DIFF_W + FRAC_W;

    typedef logic signed [SINE_W-1:0]  sine_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;
    typedef logic        [TAB_W-1:0]   tab_t;
    typedef logic        [IDX_W-1:0]   idx_t;

    localparam sine_t SINE_POS = 14'sd4096;
    localparam sine_t SINE_NEG = -14'sd4096;
    localparam tab_t  QUARTER  = 14'd8192;

    function automatic tab_t asin_entry(input idx_t idx);
        tab_t v;
        case (idx)
            7'd0:  v = 14'd0;
            7'd1:  v = 14'd81;
            7'd2:  v = 14'd163;
            7'd3:  v = 14'd245;
            7'd4:  v = 14'd326;
            7'd5:  v = 14'd408;
            7'd6:  v = 14'd490;
            7'd7:  v = 14'd572;
            7'd8:  v = 14'd654;
            7'd9:  v = 14'd736;
            7'd10: v = 14'd818;
            7'd11: v = 14'd901;
            7'd12: v = 14'd984;
            7'd13: v = 14'd1067;
            7'd14: v = 14'd1150;
            7'd15: v = 14'd1234;
            7'd16: v = 14'd1318;
            7'd17: v = 14'd1402;
            7'd18: v = 14'd1487;
            7'd19: v = 14'd1572;
            7'd20: v = 14'd1658;
            7'd21: v = 14'd1744;
            7'd22: v = 14'd1830;
            7'd23: v = 14'd1917;
            7'd24: v = 14'd2005;
            7'd25: v = 14'd2093;
            7'd26: v = 14'd2182;
            7'd27: v = 14'd2271;
            7'd28: v = 14'd2362;
            7'd29: v = 14'd2453;
            7'd30: v = 14'd2544;
            7'd31: v = 14'd2637;
            7'd32: v = 14'd2731;
            7'd33: v = 14'd2825;
            7'd34: v = 14'd2921;
            7'd35: v = 14'd3018;
            7'd36: v = 14'd3116;
            7'd37: v = 14'd3215;
            7'd38: v = 14'd3315;
            7'd39: v = 14'd3417;
            7'd40: v = 14'd3521;
            7'd41: v = 14'd3626;
            7'd42: v = 14'd3733;
            7'd43: v = 14'd3842;
            7'd44: v = 14'd3953;
            7'd45: v = 14'd4067;
            7'd46: v = 14'd4183;
            7'd47: v = 14'd4301;
            7'd48: v = 14'd4423;
            7'd49: v = 14'd4548;
            7'd50: v = 14'd4676;
            7'd51: v = 14'd4809;
            7'd52: v = 14'd4946;
            7'd53: v = 14'd5089;
            7'd54: v = 14'd5237;
            7'd55: v = 14'd5393;
            7'd56: v = 14'd5556;
            7'd57: v = 14'd5730;
            7'd58: v = 14'd5916;
            7'd59: v = 14'd6117;
            7'd60: v = 14'd6338;
            7'd61: v = 14'd6589;
            7'd62: v = 14'd6885;
            7'd63: v = 14'd7269;
            default: v = QUARTER;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/core/asti_interp.sv =====
`timescale 1ns / 1ps

module asti_interp (
    input  asti_pkg::sine_t  sine,
    output asti_pkg::angle_t angle
);
    import asti_pkg::*;

    sine_t                sat;
    logic                 neg;
    logic [MAG_W-1:0]     mag;
    idx_t                 idx;
    logic [FRAC_W-1:0]    frac;
    tab_t                 a;
    tab_t                 b;
    logic [DIFF_W-1:0]    diff;
    logic [PROD_W-1:0]    prod;
    tab_t                 r;

    always_comb
    begin
        if (sine > SINE_POS)
            sat = SINE_POS;
        else if (sine < SINE_NEG)
            sat = SINE_NEG;
        else
            sat = sine;
        neg  = sat[SINE_W-1];
        mag  = neg ? MAG_W'(-sat) : MAG_W'(sat);
        idx  = mag[MAG_W-1:FRAC_W];
        frac = mag[FRAC_W-1:0];
        a    = asin_entry(idx);
        b    = asin_entry(idx + 7'd1);
        diff = DIFF_W'(b - a);
        prod = {{FRAC_W{1'b0}}, diff} * {{DIFF_W{1'b0}}, frac};
        r    = TAB_W'(a + {{(TAB_W-(PROD_W-FRAC_W)){1'b0}}, prod[PROD_W-1:FRAC_W]});
        angle = neg ? ANGLE_W'(-$signed({1'b0, r})) : ANGLE_W'($signed({1'b0, r}));
    end

endmodule

// ===== rtl/core/arcsine_table_interpolator_top.sv =====
`timescale 1ns / 1ps
// channel   ports                         transaction
// input     start, busy, sine_in[13:0]    start && !busy at a rising edge
// result    done, angle_out[14:0]         done high for one cycle
//
// One transaction per cycle; busy never rises.
// The path runs through the input register, a table lookup with one multiply,
// and the result register.
// Reset clears the valid flags; no state survives a transaction.
// The receiver cannot stall, so results are never held.

module arcsine_table_interpolator_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  asti_pkg::sine_t  sine_in,
    output logic             done,
    output asti_pkg::angle_t angle_out
);
    import asti_pkg::*;

    logic   valid_reg;
    sine_t  sine_reg;
    logic   done_reg;
    angle_t angle_reg;
    angle_t angle_next;

    asti_interp u_interp (
        .sine  (sine_reg),
        .angle (angle_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= start && !busy;
            done_reg  <= valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sine_reg  <= sine_in;
        angle_reg <= angle_next;
    end

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign angle_out = angle_reg;

endmodule

// ===== rtl/core/asti_checker.sv =====
`timescale 1ns / 1ps

module asti_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input asti_pkg::sine_t  sine_in,
    input logic             done,
    input asti_pkg::angle_t angle_out
);
    import asti_pkg::*;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> ##1 done)
        else $error("accepted transaction gave no result");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> ##1 !done)
        else $error("result without a transaction");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle_out >= -15'sd8192) && (angle_out <= 15'sd8192))
        else $error("angle out of range");

    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && sine_in[SINE_W-1] |=> ##1 (angle_out <= 15'sd0))
        else $error("negative sine gave positive angle");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (sine_in >= SINE_POS) |=> ##1 (angle_out == 15'sd8192))
        else $error("full-scale sine did not give a quarter turn");

endmodule

bind arcsine_table_interpolator_top asti_checker u_asti_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .sine_in   (sine_in),
    .done      (done),
    .angle_out (angle_out)
);
